// File: rtl/core/ivht_pkg.sv
// Package for the interrupt vector handler table: sizes, codes, state encoding.
// No dependencies; used by the top level.
`timescale 1ns / 1ps

package ivht_pkg;

	// Table geometry
	localparam int VECTORS    = 64;
	localparam int SLOTS      = 4;
	localparam int RESULT_CAP = 4;

	// Derived widths
	localparam int VW      = $clog2(VECTORS);
	localparam int SW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int AW      = $clog2(VECTORS * SLOTS);
	localparam int NW      = $clog2(RESULT_CAP + 1);
	localparam int TOKEN_W = 32;
	localparam int ENTRY_W = 2 * TOKEN_W;

	// Stream field widths
	localparam int OP_W       = 2;
	localparam int VEC_IN_W   = 7;
	localparam int VEC_OUT_W  = 6;
	localparam int STATUS_W   = 3;
	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 72;

	typedef logic [VEC_OUT_W-1:0] vout_t;
	typedef logic [TOKEN_W-1:0]   token_t;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC = 2'd0,
		OP_ADD   = 2'd1,
		OP_TRIG  = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 3'd0,
		STAT_NO_VECTOR = 3'd1,
		STAT_NO_SLOT   = 3'd2,
		STAT_NOT_TAKEN = 3'd3,
		STAT_RANGE     = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ALLOC_SCAN,
		S_ALLOC_CLR,
		S_ADD_RD,
		S_ADD_CHK,
		S_TRIG_RD,
		S_TRIG_CHK,
		S_TRIG_FLUSH,
		S_RESP
	} state_t;

endpackage

// File: rtl/core/ivht_ram.sv
// Generic single-port RAM with registered read, used for the handler slot store.
// Depends on nothing.
`timescale 1ns / 1ps

module ivht_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write, and registered read of the old contents at the same address
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// File: rtl/core/interrupt_vector_handler_table_unit.sv
// Interrupt vector handler table: top level with sequencer, taken bits and slot RAM.
// Depends on ivht_pkg and ivht_ram.
`timescale 1ns / 1ps

// One request is handled at a time; s_axis_tready is high only while the sequencer
// is idle, and the previous result may still sit in the output register then.
// A single incrementer walks the taken bits one vector per cycle, and a single-port
// slot RAM is visited one slot at a time. Allocate scans for a free vector, wrapping
// at the top, then zeroes its slots and responds. Add reads and checks slot after
// slot until one is empty or none is left, then responds. Trigger reads and checks
// each slot, stopping after RESULT_CAP handlers, then flushes; range and not-taken
// errors go straight to the response. Back-pressure stalls any result hand-off.
// Op code 3 is dropped with no result. The slot RAM needs no clearing after reset:
// a vector's slots are zeroed when it is allocated, before any read.
module interrupt_vector_handler_table_unit
	import ivht_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// vector[6:0], handler_id[38:7], handler_arg[70:39], zero pad
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// op[1:0]
	input  logic [OP_W-1:0]       s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// vector_out[5:0], handler_out[37:6], arg_out[69:38], zero pad
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// status[2:0]
	output logic [STATUS_W-1:0]   m_axis_tuser,
	output logic                  m_axis_tlast
);

	// Input unpack
	logic [VEC_IN_W-1:0] in_vec;
	token_t              in_hnd;
	token_t              in_arg;
	logic                in_range;
	logic                in_xfer;

	assign in_vec   = s_axis_tdata[6:0];
	assign in_hnd   = s_axis_tdata[38:7];
	assign in_arg   = s_axis_tdata[70:39];
	assign in_range = {2'b00, in_vec} < 9'(VECTORS);
	assign in_xfer  = s_axis_tvalid && s_axis_tready;

	// Registers
	state_t              state_q, state_d;
	logic [VECTORS-1:0]  taken_q, taken_d;
	logic [VW-1:0]       vec_q, vec_d;
	logic [VW-1:0]       scan_cnt_q, scan_cnt_d;
	logic [SW-1:0]       slot_q, slot_d;
	logic [NW-1:0]       trig_n_q, trig_n_d;
	logic                pend_valid_q, pend_valid_d;
	token_t              pend_hnd_q, pend_hnd_d;
	token_t              pend_arg_q, pend_arg_d;
	token_t              hnd_q, hnd_d;
	token_t              arg_q, arg_d;
	status_t             res_status_q, res_status_d;
	vout_t               res_vec_q, res_vec_d;

	// Output register
	logic                m_valid_q;
	status_t             m_status_q;
	vout_t               m_vec_q;
	token_t              m_hnd_q, m_arg_q;
	logic                m_last_q;
	logic                out_free;
	logic                out_load;
	status_t             out_status;
	vout_t               out_vec;
	token_t              out_hnd, out_arg;
	logic                out_last;

	// Slot RAM
	logic                ram_we;
	logic [AW-1:0]       ram_addr;
	logic [ENTRY_W-1:0]  ram_wdata;
	logic [ENTRY_W-1:0]  ram_rdata;
	token_t              rd_hnd, rd_arg;
	logic                last_slot;
	logic [NW-1:0]       trig_n_inc;

	assign out_free   = !m_valid_q || m_axis_tready;
	assign ram_addr   = AW'(AW'(vec_q) * AW'(SLOTS)) + AW'(slot_q);
	assign rd_hnd     = ram_rdata[TOKEN_W-1:0];
	assign rd_arg     = ram_rdata[ENTRY_W-1:TOKEN_W];
	assign last_slot  = slot_q == SW'(SLOTS - 1);
	assign trig_n_inc = trig_n_q + NW'(1);

	ivht_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(VECTORS * SLOTS)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// Sequencer: next state, datapath updates, result hand-off
	always_comb begin
		state_d      = state_q;
		taken_d      = taken_q;
		vec_d        = vec_q;
		scan_cnt_d   = scan_cnt_q;
		slot_d       = slot_q;
		trig_n_d     = trig_n_q;
		pend_valid_d = pend_valid_q;
		pend_hnd_d   = pend_hnd_q;
		pend_arg_d   = pend_arg_q;
		hnd_d        = hnd_q;
		arg_d        = arg_q;
		res_status_d = res_status_q;
		res_vec_d    = res_vec_q;
		ram_we       = 1'b0;
		ram_wdata    = '0;
		out_load     = 1'b0;
		out_status   = STAT_OK;
		out_vec      = vout_t'(vec_q);
		out_hnd      = '0;
		out_arg      = '0;
		out_last     = 1'b1;
		s_axis_tready = (state_q == S_IDLE);

		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					hnd_d      = in_hnd;
					arg_d      = in_arg;
					slot_d     = '0;
					scan_cnt_d = '0;
					trig_n_d   = '0;
					pend_valid_d = 1'b0;
					vec_d      = in_range ? VW'(in_vec) : '0;
					case (s_axis_tuser)
						OP_ALLOC: begin
							state_d = S_ALLOC_SCAN;
						end
						OP_ADD, OP_TRIG: begin
							if (!in_range) begin
								res_status_d = STAT_RANGE;
								res_vec_d    = '0;
								state_d      = S_RESP;
							end else if (!taken_q[VW'(in_vec)]) begin
								res_status_d = STAT_NOT_TAKEN;
								res_vec_d    = vout_t'(in_vec);
								state_d      = S_RESP;
							end else if (s_axis_tuser == OP_ADD) begin
								state_d = S_ADD_RD;
							end else begin
								state_d = S_TRIG_RD;
							end
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end

			// One vector per cycle, wrapping at the top
			S_ALLOC_SCAN: begin
				if (!taken_q[vec_q]) begin
					taken_d[vec_q] = 1'b1;
					state_d        = S_ALLOC_CLR;
				end else if (scan_cnt_q == VW'(VECTORS - 1)) begin
					res_status_d = STAT_NO_VECTOR;
					res_vec_d    = '0;
					state_d      = S_RESP;
				end else begin
					scan_cnt_d = scan_cnt_q + VW'(1);
					vec_d      = (vec_q == VW'(VECTORS - 1)) ? '0 : vec_q + VW'(1);
				end
			end

			// Zero the claimed vector's slots
			S_ALLOC_CLR: begin
				ram_we = 1'b1;
				if (last_slot) begin
					res_status_d = STAT_OK;
					res_vec_d    = vout_t'(vec_q);
					state_d      = S_RESP;
				end else begin
					slot_d = slot_q + SW'(1);
				end
			end

			S_ADD_RD: begin
				state_d = S_ADD_CHK;
			end

			// First empty slot takes the handler
			S_ADD_CHK: begin
				res_vec_d = vout_t'(vec_q);
				if (rd_hnd == '0) begin
					ram_we       = 1'b1;
					ram_wdata    = {arg_q, hnd_q};
					res_status_d = STAT_OK;
					state_d      = S_RESP;
				end else if (last_slot) begin
					res_status_d = STAT_NO_SLOT;
					state_d      = S_RESP;
				end else begin
					slot_d  = slot_q + SW'(1);
					state_d = S_ADD_RD;
				end
			end

			S_TRIG_RD: begin
				state_d = S_TRIG_CHK;
			end

			// Hold one handler back so the final one can carry tlast
			S_TRIG_CHK: begin
				if (rd_hnd != '0 && pend_valid_q && !out_free) begin
					state_d = S_TRIG_CHK;
				end else begin
					if (rd_hnd != '0) begin
						if (pend_valid_q) begin
							out_load = 1'b1;
							out_hnd  = pend_hnd_q;
							out_arg  = pend_arg_q;
							out_last = 1'b0;
						end
						pend_valid_d = 1'b1;
						pend_hnd_d   = rd_hnd;
						pend_arg_d   = rd_arg;
						trig_n_d     = trig_n_inc;
					end
					if (last_slot || (rd_hnd != '0 && trig_n_inc == NW'(RESULT_CAP))) begin
						state_d = S_TRIG_FLUSH;
					end else begin
						slot_d  = slot_q + SW'(1);
						state_d = S_TRIG_RD;
					end
				end
			end

			S_TRIG_FLUSH: begin
				if (out_free) begin
					out_load = 1'b1;
					out_hnd  = pend_valid_q ? pend_hnd_q : '0;
					out_arg  = pend_valid_q ? pend_arg_q : '0;
					state_d  = S_IDLE;
				end
			end

			S_RESP: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_status = res_status_q;
					out_vec    = res_vec_q;
					state_d    = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			taken_q      <= '0;
			pend_valid_q <= 1'b0;
			trig_n_q     <= '0;
			m_valid_q    <= 1'b0;
		end else begin
			state_q      <= state_d;
			taken_q      <= taken_d;
			pend_valid_q <= pend_valid_d;
			trig_n_q     <= trig_n_d;
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		vec_q        <= vec_d;
		scan_cnt_q   <= scan_cnt_d;
		slot_q       <= slot_d;
		pend_hnd_q   <= pend_hnd_d;
		pend_arg_q   <= pend_arg_d;
		hnd_q        <= hnd_d;
		arg_q        <= arg_d;
		res_status_q <= res_status_d;
		res_vec_q    <= res_vec_d;
		if (out_load) begin
			m_status_q <= out_status;
			m_vec_q    <= out_vec;
			m_hnd_q    <= out_hnd;
			m_arg_q    <= out_arg;
			m_last_q   <= out_last;
		end
	end

	// Output pack
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_status_q;
	assign m_axis_tlast  = m_last_q;
	assign m_axis_tdata  = {2'b00, m_arg_q, m_hnd_q, m_vec_q};

	// Checks
	a_taken_grows: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(taken_q) >= $past($countones(taken_q)))
		else $error("taken bits cleared outside reset");

	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != STAT_OK |-> m_axis_tlast)
		else $error("error result not marked last");

	a_handler_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[37:6] != '0 |-> m_axis_tuser == STAT_OK)
		else $error("handler emitted with error status");

	a_trig_cap: assert property (@(posedge clk) disable iff (!arst_n)
		trig_n_q <= NW'(RESULT_CAP))
		else $error("trigger emitted beyond result cap");

endmodule
